// File: hdl/jdcal_pkg.sv
`timescale 1ns / 1ps

package jdcal_pkg;

    // pipeline depth, the same for the date and the time-of-day paths
    localparam int NUM_STAGES = 7;

    // configuration port
    localparam int PADDR_W    = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_CALENDAR_MODE = 1'b0;

    // calendar_mode codes
    localparam logic [1:0] CAL_JULIAN    = 2'd0;
    localparam logic [1:0] CAL_GREGORIAN = 2'd1;
    localparam logic [1:0] CAL_SWITCH    = 2'd2;

    // first day of the gregorian reform
    localparam logic [22:0] SWITCH_DAY = 23'd2299161;

    // time of day
    localparam logic [26:0] MS_PER_DAY  = 27'd86400000;
    localparam logic [26:0] MS_MAX      = MS_PER_DAY - 27'd1;
    localparam logic [26:0] MS_PER_HOUR = 27'd3600000;
    localparam logic [21:0] MS_PER_MIN  = 22'd60000;
    localparam logic [15:0] MS_PER_SEC  = 16'd1000;
    localparam logic [23:0] DAYS_PER_WEEK = 24'd7;

    // reciprocal constants: q = (n * MUL) >> SHIFT, MUL = ceil(2^SHIFT / divisor),
    // SHIFT = input width plus divisor width, which keeps the quotient exact
    localparam int HOUR_SHIFT = 49;
    localparam logic [27:0] HOUR_MUL =
        28'(((64'd1 << HOUR_SHIFT) + 64'd3599999) / 64'd3600000);
    localparam int MIN_SHIFT = 38;
    localparam logic [22:0] MIN_MUL =
        23'(((64'd1 << MIN_SHIFT) + 64'd59999) / 64'd60000);
    localparam int SEC_SHIFT = 26;
    localparam logic [16:0] SEC_MUL =
        17'(((64'd1 << SEC_SHIFT) + 64'd999) / 64'd1000);
    localparam int WEEK_SHIFT = 27;
    localparam logic [24:0] WEEK_MUL =
        25'(((64'd1 << WEEK_SHIFT) + 64'd6) / 64'd7);

    // alpha = trunc((4z - 7468865) / 146097)
    localparam logic signed [25:0] ALPHA_OFS = 26'sd7468865;
    localparam int ALPHA_SHIFT = 43;
    localparam logic [25:0] ALPHA_MUL =
        26'(((64'd1 << ALPHA_SHIFT) + 64'd146096) / 64'd146097);

    // b = a + 1524, gregorian path folds the +1 of a into the offset
    localparam logic [10:0] B_OFS_JULIAN = 11'd1524;
    localparam logic [10:0] B_OFS_GREG   = 11'd1525;

    // c = trunc((20b - 2442) / 7305)
    localparam logic [27:0] C_OFS = 28'd2442;
    localparam int C_SHIFT = 41;
    localparam logic [28:0] C_MUL =
        29'(((64'd1 << C_SHIFT) + 64'd7304) / 64'd7305);

    // d = trunc(1461c / 4)
    localparam logic [25:0] D_MUL = 26'd1461;

    // year offset and highest month index searched
    localparam logic [15:0] YEAR_OFS = 16'd4716;
    localparam int E_MAX = 16;

    typedef struct packed {
        logic [22:0] day_number;
        logic [26:0] ms_of_day;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] year;
        logic [3:0]         month;
        logic [4:0]         day_of_month;
        logic [4:0]         hour;
        logic [5:0]         minute;
        logic [5:0]         second;
        logic [9:0]         millisecond;
        logic [2:0]         weekday;
        logic               gregorian_used;
    } out_item_t;

    typedef struct packed {
        logic signed [15:0] year;
        logic [3:0]         month;
        logic [4:0]         day_of_month;
        logic               gregorian_used;
    } date_t;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [9:0] millisecond;
        logic [2:0] weekday;
    } tod_t;

    // floor(30.6001 * k), start of month index k counted from b - d
    function automatic logic [9:0] e_base(input logic [4:0] k);
        case (k)
            5'd1:    e_base = 10'd30;
            5'd2:    e_base = 10'd61;
            5'd3:    e_base = 10'd91;
            5'd4:    e_base = 10'd122;
            5'd5:    e_base = 10'd153;
            5'd6:    e_base = 10'd183;
            5'd7:    e_base = 10'd214;
            5'd8:    e_base = 10'd244;
            5'd9:    e_base = 10'd275;
            5'd10:   e_base = 10'd306;
            5'd11:   e_base = 10'd336;
            5'd12:   e_base = 10'd367;
            5'd13:   e_base = 10'd397;
            5'd14:   e_base = 10'd428;
            5'd15:   e_base = 10'd459;
            5'd16:   e_base = 10'd489;
            5'd17:   e_base = 10'd520;
            default: e_base = 10'd0;
        endcase
    endfunction

endpackage

// File: hdl/jdcal_pipe_ctl.sv
`timescale 1ns / 1ps

module jdcal_pipe_ctl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [jdcal_pkg::NUM_STAGES-1:0] load
);

    logic [jdcal_pkg::NUM_STAGES-1:0] valid_reg;
    logic [jdcal_pkg::NUM_STAGES-1:0] valid_next;

    // a stage loads when empty or when its content moves on
    always_comb
    begin
        load[jdcal_pkg::NUM_STAGES-1] = !valid_reg[jdcal_pkg::NUM_STAGES-1] || out_ready;
        for (int k = jdcal_pkg::NUM_STAGES - 2; k >= 0; k--)
        begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    // valid bits follow the data
    always_comb
    begin
        valid_next[0] = load[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < jdcal_pkg::NUM_STAGES; k++)
        begin
            valid_next[k] = load[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = load[0];
    assign out_valid = valid_reg[jdcal_pkg::NUM_STAGES-1];

endmodule

// File: hdl/jdcal_date.sv
`timescale 1ns / 1ps

module jdcal_date (
    input  logic                             clk,
    input  logic [jdcal_pkg::NUM_STAGES-1:0] load,
    input  logic [1:0]                       calendar_mode,
    input  logic [22:0]                      day_number,
    output jdcal_pkg::date_t                 date
);

    // stage 0: calendar choice and alpha numerator magnitude
    logic               greg_s0;
    logic signed [25:0] anum_s0;
    logic [24:0]        amag_s0;
    logic [22:0]        z0_reg;
    logic               greg0_reg;
    logic               neg0_reg;
    logic [24:0]        amag0_reg;

    always_comb
    begin
        case (calendar_mode)
            jdcal_pkg::CAL_JULIAN:    greg_s0 = 1'b0;
            jdcal_pkg::CAL_GREGORIAN: greg_s0 = 1'b1;
            jdcal_pkg::CAL_SWITCH:    greg_s0 = (day_number >= jdcal_pkg::SWITCH_DAY);
            default:                  greg_s0 = 1'b1;
        endcase
        anum_s0 = $signed({1'b0, day_number, 2'b00}) - jdcal_pkg::ALPHA_OFS;
        amag_s0 = anum_s0[25] ? 25'(-anum_s0) : anum_s0[24:0];
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            z0_reg    <= day_number;
            greg0_reg <= greg_s0;
            neg0_reg  <= anum_s0[25];
            amag0_reg <= amag_s0;
        end
    end

    // stage 1: alpha magnitude by reciprocal multiply
    logic [50:0] aprod_s1;
    logic [22:0] z1_reg;
    logic        greg1_reg;
    logic        neg1_reg;
    logic [7:0]  alpha1_reg;

    assign aprod_s1 = 51'(amag0_reg) * 51'(jdcal_pkg::ALPHA_MUL);

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            z1_reg     <= z0_reg;
            greg1_reg  <= greg0_reg;
            neg1_reg   <= neg0_reg;
            alpha1_reg <= 8'(aprod_s1 >> jdcal_pkg::ALPHA_SHIFT);
        end
    end

    // stage 2: b and the numerator of c
    logic [7:0]  corr_s2;
    logic [10:0] bofs_s2;
    logic [23:0] b_s2;
    logic [27:0] cnum_s2;
    logic [23:0] b2_reg;
    logic [27:0] cnum2_reg;
    logic        greg2_reg;

    always_comb
    begin
        // alpha - trunc(alpha / 4), sign applied separately
        corr_s2 = alpha1_reg - (alpha1_reg >> 2);
        if (!greg1_reg)
        begin
            bofs_s2 = jdcal_pkg::B_OFS_JULIAN;
        end
        else if (neg1_reg)
        begin
            bofs_s2 = jdcal_pkg::B_OFS_GREG - {3'd0, corr_s2};
        end
        else
        begin
            bofs_s2 = jdcal_pkg::B_OFS_GREG + {3'd0, corr_s2};
        end
        b_s2    = {1'b0, z1_reg} + {13'd0, bofs_s2};
        cnum_s2 = {b_s2, 4'b0000} + 28'({b_s2, 2'b00}) - jdcal_pkg::C_OFS;
    end

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            b2_reg    <= b_s2;
            cnum2_reg <= cnum_s2;
            greg2_reg <= greg1_reg;
        end
    end

    // stage 3: c by reciprocal multiply
    logic [56:0] cprod_s3;
    logic [23:0] b3_reg;
    logic [14:0] c3_reg;
    logic        greg3_reg;

    assign cprod_s3 = 57'(cnum2_reg) * 57'(jdcal_pkg::C_MUL);

    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            b3_reg    <= b2_reg;
            c3_reg    <= 15'(cprod_s3 >> jdcal_pkg::C_SHIFT);
            greg3_reg <= greg2_reg;
        end
    end

    // stage 4: d = 1461c / 4
    logic [25:0] dprod_s4;
    logic [23:0] b4_reg;
    logic [14:0] c4_reg;
    logic [23:0] d4_reg;
    logic        greg4_reg;

    assign dprod_s4 = 26'(c3_reg) * jdcal_pkg::D_MUL;

    always_ff @(posedge clk)
    begin
        if (load[4])
        begin
            b4_reg    <= b3_reg;
            c4_reg    <= c3_reg;
            d4_reg    <= dprod_s4[25:2];
            greg4_reg <= greg3_reg;
        end
    end

    // stage 5: day within the march-based year
    logic [9:0]  bd5_reg;
    logic [14:0] c5_reg;
    logic        greg5_reg;

    always_ff @(posedge clk)
    begin
        if (load[5])
        begin
            bd5_reg   <= 10'(b4_reg - d4_reg);
            c5_reg    <= c4_reg;
            greg5_reg <= greg4_reg;
        end
    end

    // stage 6: month index by threshold search, then day, month and year
    logic [4:0]         e_s6;
    logic [4:0]         day_s6;
    logic [3:0]         month_s6;
    logic [15:0]        year_s6;
    logic signed [15:0] year6_reg;
    logic [3:0]         month6_reg;
    logic [4:0]         day6_reg;
    logic               greg6_reg;

    always_comb
    begin
        // 30.6001k is never whole, so k is reached once b - d exceeds its floor
        e_s6 = 5'd0;
        for (int k = 1; k <= jdcal_pkg::E_MAX; k++)
        begin
            if (bd5_reg > jdcal_pkg::e_base(5'(k)))
            begin
                e_s6 = 5'(k);
            end
        end
        day_s6   = 5'(bd5_reg - jdcal_pkg::e_base(e_s6));
        month_s6 = (e_s6 < 5'd14) ? 4'(e_s6 - 5'd1) : 4'(e_s6 - 5'd13);
        year_s6  = {1'b0, c5_reg} + {15'd0, (month_s6 <= 4'd2)} - jdcal_pkg::YEAR_OFS;
    end

    always_ff @(posedge clk)
    begin
        if (load[6])
        begin
            year6_reg  <= $signed(year_s6);
            month6_reg <= month_s6;
            day6_reg   <= day_s6;
            greg6_reg  <= greg5_reg;
        end
    end

    always_comb
    begin
        date.year           = year6_reg;
        date.month          = month6_reg;
        date.day_of_month   = day6_reg;
        date.gregorian_used = greg6_reg;
    end

endmodule

// File: hdl/jdcal_tod.sv
`timescale 1ns / 1ps

module jdcal_tod (
    input  logic                             clk,
    input  logic [jdcal_pkg::NUM_STAGES-1:0] load,
    input  logic [22:0]                      day_number,
    input  logic [26:0]                      ms_of_day,
    output jdcal_pkg::tod_t                  tod
);

    // stage 0: saturate the millisecond count, weekday numerator
    logic [26:0] ms0_reg;
    logic [23:0] wn0_reg;

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            ms0_reg <= (ms_of_day >= jdcal_pkg::MS_PER_DAY) ? jdcal_pkg::MS_MAX : ms_of_day;
            wn0_reg <= {1'b0, day_number} + 24'd1;
        end
    end

    // stage 1: hour and week count by reciprocal multiply
    logic [54:0] hprod_s1;
    logic [48:0] wprod_s1;
    logic [26:0] ms1_reg;
    logic [4:0]  hour1_reg;
    logic [23:0] wn1_reg;
    logic [20:0] wq1_reg;

    assign hprod_s1 = 55'(ms0_reg) * 55'(jdcal_pkg::HOUR_MUL);
    assign wprod_s1 = 49'(wn0_reg) * 49'(jdcal_pkg::WEEK_MUL);

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            ms1_reg   <= ms0_reg;
            hour1_reg <= 5'(hprod_s1 >> jdcal_pkg::HOUR_SHIFT);
            wn1_reg   <= wn0_reg;
            wq1_reg   <= 21'(wprod_s1 >> jdcal_pkg::WEEK_SHIFT);
        end
    end

    // stage 2: remainders of the hour and the week
    logic [26:0] remh_s2;
    logic [23:0] wrem_s2;
    logic [21:0] remh2_reg;
    logic [4:0]  hour2_reg;
    logic [2:0]  wd2_reg;

    always_comb
    begin
        remh_s2 = ms1_reg - 27'(hour1_reg) * jdcal_pkg::MS_PER_HOUR;
        wrem_s2 = wn1_reg - 24'(wq1_reg) * jdcal_pkg::DAYS_PER_WEEK;
    end

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            remh2_reg <= remh_s2[21:0];
            hour2_reg <= hour1_reg;
            wd2_reg   <= wrem_s2[2:0];
        end
    end

    // stage 3: minute by reciprocal multiply
    logic [44:0] mprod_s3;
    logic [21:0] remh3_reg;
    logic [5:0]  min3_reg;
    logic [4:0]  hour3_reg;
    logic [2:0]  wd3_reg;

    assign mprod_s3 = 45'(remh2_reg) * 45'(jdcal_pkg::MIN_MUL);

    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            remh3_reg <= remh2_reg;
            min3_reg  <= 6'(mprod_s3 >> jdcal_pkg::MIN_SHIFT);
            hour3_reg <= hour2_reg;
            wd3_reg   <= wd2_reg;
        end
    end

    // stage 4: remainder of the minute
    logic [21:0] remm_s4;
    logic [15:0] remm4_reg;
    logic [5:0]  min4_reg;
    logic [4:0]  hour4_reg;
    logic [2:0]  wd4_reg;

    assign remm_s4 = remh3_reg - 22'(min3_reg) * jdcal_pkg::MS_PER_MIN;

    always_ff @(posedge clk)
    begin
        if (load[4])
        begin
            remm4_reg <= remm_s4[15:0];
            min4_reg  <= min3_reg;
            hour4_reg <= hour3_reg;
            wd4_reg   <= wd3_reg;
        end
    end

    // stage 5: second by reciprocal multiply
    logic [32:0] sprod_s5;
    logic [15:0] remm5_reg;
    logic [5:0]  sec5_reg;
    logic [5:0]  min5_reg;
    logic [4:0]  hour5_reg;
    logic [2:0]  wd5_reg;

    assign sprod_s5 = 33'(remm4_reg) * 33'(jdcal_pkg::SEC_MUL);

    always_ff @(posedge clk)
    begin
        if (load[5])
        begin
            remm5_reg <= remm4_reg;
            sec5_reg  <= 6'(sprod_s5 >> jdcal_pkg::SEC_SHIFT);
            min5_reg  <= min4_reg;
            hour5_reg <= hour4_reg;
            wd5_reg   <= wd4_reg;
        end
    end

    // stage 6: millisecond remainder
    logic [15:0] msec_s6;
    logic [9:0]  msec6_reg;
    logic [5:0]  sec6_reg;
    logic [5:0]  min6_reg;
    logic [4:0]  hour6_reg;
    logic [2:0]  wd6_reg;

    assign msec_s6 = remm5_reg - 16'(sec5_reg) * jdcal_pkg::MS_PER_SEC;

    always_ff @(posedge clk)
    begin
        if (load[6])
        begin
            msec6_reg <= msec_s6[9:0];
            sec6_reg  <= sec5_reg;
            min6_reg  <= min5_reg;
            hour6_reg <= hour5_reg;
            wd6_reg   <= wd5_reg;
        end
    end

    always_comb
    begin
        tod.hour        = hour6_reg;
        tod.minute      = min6_reg;
        tod.second      = sec6_reg;
        tod.millisecond = msec6_reg;
        tod.weekday     = wd6_reg;
    end

endmodule

// File: hdl/julian_day_to_calendar_date.sv
// channel   direction  handshake              content
// in        input      in_valid / in_ready    day_number, ms_of_day
// out       output     out_valid / out_ready  calendar date, time of day, weekday
// apb       input      psel / penable         calendar_mode at byte address 0
//
// seven register stages, which a transfer in passes through to reach out_valid;
// one transfer per cycle is sustained while out_ready is high; the deepest
// stage is the 28 x 29 bit reciprocal multiply that yields the year count
// reset clears every stage valid bit and sets calendar_mode to 2
// a stall on out holds only the stages that are full; empty stages keep
// filling, so in stays ready until the whole pipeline is occupied
`timescale 1ns / 1ps

module julian_day_to_calendar_date (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  jdcal_pkg::in_item_t                 in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output jdcal_pkg::out_item_t                out_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [jdcal_pkg::PADDR_W-1:0]       paddr,
    input  logic [jdcal_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [jdcal_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);

    logic [1:0]                       calendar_mode_reg;
    logic [1:0]                       calendar_mode_next;
    logic                             reg_index;
    logic                             cfg_write;
    logic [jdcal_pkg::NUM_STAGES-1:0] load;
    jdcal_pkg::date_t                 date;
    jdcal_pkg::tod_t                  tod;

    // register port, no wait states
    assign pready    = 1'b1;
    assign reg_index = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        calendar_mode_next = calendar_mode_reg;
        if (cfg_write && (reg_index == jdcal_pkg::REG_CALENDAR_MODE))
        begin
            calendar_mode_next = pwdata[1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calendar_mode_reg <= jdcal_pkg::CAL_SWITCH;
        end
        else
        begin
            calendar_mode_reg <= calendar_mode_next;
        end
    end

    // read back
    always_comb
    begin
        if (reg_index == jdcal_pkg::REG_CALENDAR_MODE)
        begin
            prdata = {{(jdcal_pkg::APB_DATA_W - 2){1'b0}}, calendar_mode_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    // stage control
    jdcal_pipe_ctl u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .load      (load)
    );

    // calendar date path
    jdcal_date u_date (
        .clk           (clk),
        .load          (load),
        .calendar_mode (calendar_mode_reg),
        .day_number    (in_data.day_number),
        .date          (date)
    );

    // time of day and weekday path
    jdcal_tod u_tod (
        .clk        (clk),
        .load       (load),
        .day_number (in_data.day_number),
        .ms_of_day  (in_data.ms_of_day),
        .tod        (tod)
    );

    // result assembly
    always_comb
    begin
        out_data.year           = date.year;
        out_data.month          = date.month;
        out_data.day_of_month   = date.day_of_month;
        out_data.hour           = tod.hour;
        out_data.minute         = tod.minute;
        out_data.second         = tod.second;
        out_data.millisecond    = tod.millisecond;
        out_data.weekday        = tod.weekday;
        out_data.gregorian_used = date.gregorian_used;
    end

endmodule

// File: hdl/jdcal_checker.sv
`timescale 1ns / 1ps

module jdcal_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             out_valid,
    input logic                             out_ready,
    input jdcal_pkg::out_item_t             out_data,
    input logic                             psel,
    input logic                             penable,
    input logic                             pwrite,
    input logic                             pready,
    input logic [jdcal_pkg::PADDR_W-1:0]    paddr,
    input logic [jdcal_pkg::APB_DATA_W-1:0] pwdata,
    input logic [jdcal_pkg::APB_DATA_W-1:0] prdata
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("result changed while stalled");

    // a write to calendar_mode reads back on the next transfer
    a_mode_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready
            && paddr[2] == jdcal_pkg::REG_CALENDAR_MODE)
        ##1 (psel && !pwrite && paddr[2] == jdcal_pkg::REG_CALENDAR_MODE)
        |-> prdata[1:0] == $past(pwdata[1:0]))
        else $error("calendar_mode read back differs from write");

    // every offered result is a well-formed date and time
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.month >= 4'd1 && out_data.month <= 4'd12
            && out_data.day_of_month != 5'd0 && out_data.hour <= 5'd23
            && out_data.minute <= 6'd59 && out_data.second <= 6'd59
            && out_data.millisecond <= 10'd999 && out_data.weekday <= 3'd6))
        else $error("result field out of range");

endmodule

bind julian_day_to_calendar_date jdcal_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
);
